// File: rtl/core/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types, constants and a hex-decode helper for the HTTP chunk header checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcc_pkg;

  localparam int unsigned MaxHexDigits = 16;
  localparam int unsigned SizeW        = 64;
  localparam int unsigned OffsetW      = 5;

  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  typedef enum logic [1:0] {
    ST_NEED     = 2'd0,
    ST_ERROR    = 2'd1,
    ST_COMPLETE = 2'd2
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [OffsetW-1:0]   offset;
    logic [SizeW-1:0]     size;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hcc_parse.sv
// ----------------------------------------------------------------------------
// hcc_parse
// Chunk framing state and per-byte verdict logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcc_parse (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            start_of_buffer_i,
  output hcc_pkg::result_t     result_o
);
  import hcc_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_LF      = 3'd2,
    PH_DOOMED  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SUFFIX1 = 3'd5,
    PH_SUFFIX2 = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  localparam logic [OffsetW-1:0] DigitMax = OffsetW'(MaxHexDigits);

  phase_e             phase_q, phase_d, phase_c;
  logic [OffsetW-1:0] dcnt_q, dcnt_d, dcnt_c;
  logic [SizeW-1:0]   acc_q, acc_d, acc_c;
  logic [SizeW-1:0]   pcnt_q, pcnt_d, pcnt_c, pcnt_inc;
  logic               crok_q, crok_d, crok_c;
  hex_t               hex;
  result_t            res;

  always_comb begin
    hex     = hex_decode(data_byte_i);
    phase_c = start_of_buffer_i ? PH_FIRST : phase_q;
    dcnt_c  = start_of_buffer_i ? '0 : dcnt_q;
    acc_c   = start_of_buffer_i ? '0 : acc_q;
    pcnt_c  = start_of_buffer_i ? '0 : pcnt_q;
    crok_c  = start_of_buffer_i ? 1'b0 : crok_q;
    pcnt_inc = pcnt_c + SizeW'(1);

    phase_d    = phase_c;
    dcnt_d     = dcnt_c;
    acc_d      = acc_c;
    pcnt_d     = pcnt_c;
    crok_d     = crok_c;
    res.status = ST_NEED;
    res.offset = '0;
    res.size   = '0;

    case (phase_c)
      PH_FIRST: begin
        if (!hex.ok) begin
          phase_d = PH_ERROR;
        end else begin
          acc_d   = SizeW'(hex.val);
          dcnt_d  = OffsetW'(1);
          phase_d = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (hex.ok && dcnt_c < DigitMax) begin
          acc_d  = {acc_c[SizeW-5:0], hex.val};
          dcnt_d = dcnt_c + OffsetW'(1);
        end else if (data_byte_i == CharCr) begin
          phase_d = PH_LF;
        end else begin
          phase_d = PH_DOOMED;
        end
      end
      PH_LF: begin
        if (data_byte_i != CharLf) begin
          phase_d = PH_ERROR;
        end else if (acc_c == '0) begin
          res.status = ST_COMPLETE;
          res.offset = dcnt_c + OffsetW'(2);
          phase_d    = PH_FIRST;
          dcnt_d     = '0;
          acc_d      = '0;
          pcnt_d     = '0;
          crok_d     = 1'b0;
        end else begin
          pcnt_d  = '0;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pcnt_d = pcnt_inc;
        if (pcnt_inc == acc_c) phase_d = PH_SUFFIX1;
      end
      PH_SUFFIX1: begin
        crok_d  = (data_byte_i == CharCr);
        phase_d = PH_SUFFIX2;
      end
      PH_SUFFIX2: begin
        if (crok_c && data_byte_i == CharLf) begin
          res.status = ST_COMPLETE;
          res.offset = dcnt_c + OffsetW'(2);
          res.size   = acc_c;
          phase_d    = PH_FIRST;
          dcnt_d     = '0;
          acc_d      = '0;
          pcnt_d     = '0;
          crok_d     = 1'b0;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase

    if (phase_d == PH_ERROR) begin
      res.status = ST_ERROR;
      res.offset = '0;
      res.size   = '0;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      dcnt_q  <= '0;
      acc_q   <= '0;
      pcnt_q  <= '0;
      crok_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      dcnt_q  <= dcnt_d;
      acc_q   <= acc_d;
      pcnt_q  <= pcnt_d;
      crok_q  <= crok_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/http_chunk_header_checker.sv
// ----------------------------------------------------------------------------
// http_chunk_header_checker
// Byte-wise checker for HTTP chunked framing.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one byte per transfer with
// start_of_buffer_i, which clears the parse state before that byte is used.
// Output channel: out_valid_o / out_stall_i carry one verdict per input byte:
// status_o (need more, error, complete), chunk_offset_o and chunk_size_o;
// the latter two are zero unless status_o is complete.
// A byte taken from the input channel is held in the input register, judged
// by the parser while the output register can accept, and its verdict is then
// registered in the output register, which drives out_valid_o.
// Throughput: one byte per cycle while the receiver does not stall, as the
// parser updates phase, digit count, size and the 64-bit payload counter.
// Reset clears both pipeline valids and returns the parser to expecting the
// first hex digit of a chunk.
// When the receiver stalls, the output register holds its verdict, the
// parser stops, and the input register, if empty, still takes one byte
// before in_stall_o rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_chunk_header_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 data_byte_i,
  input  wire logic                       start_of_buffer_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      status_o,
  output logic [hcc_pkg::OffsetW-1:0]     chunk_offset_o,
  output logic [hcc_pkg::SizeW-1:0]       chunk_size_o
);
  import hcc_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_sob_q;
  logic       out_valid_q;
  result_t    out_res_q;
  result_t    parse_res;
  logic       out_ready, advance, in_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = in_valid_q && out_ready;
  assign in_ready  = !in_valid_q || advance;

  hcc_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .data_byte_i       (in_byte_q),
    .start_of_buffer_i (in_sob_q),
    .result_o          (parse_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready)  in_valid_q  <= in_valid_i;
      if (out_ready) out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_sob_q  <= start_of_buffer_i;
    end
    if (advance) out_res_q <= parse_res;
  end

  assign in_stall_o     = !in_ready;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign chunk_offset_o = out_res_q.offset;
  assign chunk_size_o   = out_res_q.size;

endmodule

`default_nettype wire

// File: rtl/core/hcc_checker.sv
// ----------------------------------------------------------------------------
// hcc_checker
// Port-level checks for the HTTP chunk header checker, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [1:0]                 status_o,
  input wire logic [hcc_pkg::OffsetW-1:0] chunk_offset_o,
  input wire logic [hcc_pkg::SizeW-1:0]  chunk_size_o
);
  import hcc_pkg::*;

  // held verdict on a stalled transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(chunk_offset_o) && $stable(chunk_size_o))
    else $error("output changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_NEED || status_o == ST_ERROR
      || status_o == ST_COMPLETE))
    else $error("undefined status code");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_COMPLETE |-> chunk_offset_o == '0
      && chunk_size_o == '0)
    else $error("nonzero fields without complete");

  a_offs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_COMPLETE |->
      chunk_offset_o >= OffsetW'(3) && chunk_offset_o <= OffsetW'(MaxHexDigits + 2))
    else $error("chunk offset out of range");

endmodule

bind http_chunk_header_checker hcc_checker u_hcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .chunk_offset_o (chunk_offset_o),
  .chunk_size_o   (chunk_size_o)
);

`default_nettype wire
